// ----- src/efc_pkg.sv -----
// Shared types, constants and saturation helpers for the 1D Euler flux block.
// No dependencies; every other file in src but efc_delay imports this package.
`timescale 1ns / 1ps

package efc_pkg;

    localparam int QW = 48;          // signed Q16.32 word
    localparam int GAMMA_W = 34;     // unsigned Q2.32 gamma

    typedef logic signed [QW-1:0] t_q;

    typedef struct packed {
        t_q density;
        t_q momentum;
        t_q total_energy;
    } t_efc_in;

    typedef struct packed {
        t_q flux_mass;
        t_q flux_momentum;
        t_q flux_energy;
        t_q speed_minus;
        t_q speed_mid;
        t_q speed_plus;
        t_q left_row0_col0;
        t_q left_row0_col1;
        t_q left_row1_col0;
        t_q left_row1_col1;
        t_q left_row2_col0;
        t_q left_row2_col1;
    } t_efc_out;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 34'd6012954214;  // 1.4
    localparam logic [GAMMA_W-1:0] GAMMA_MIN   = 34'd4294967297;  // just above 1
    localparam logic [GAMMA_W-1:0] ONE_Q       = 34'h1_0000_0000;

    localparam t_q FLOOR_Q = 48'sd4295;                 // 1e-6
    localparam t_q Q_MAX   = {1'b0, {(QW-1){1'b1}}};
    localparam t_q Q_MIN   = {1'b1, {(QW-1){1'b0}}};

    // unit latencies in cycles
    localparam int MUL_LAT  = 2;
    localparam int DIV_LAT  = QW + 2;
    localparam int SQRT_LAT = 41;

    function automatic t_q sat50(input logic [QW+1:0] x);
        t_q r;
        if (x[QW+1:QW-1] == 3'b000 || x[QW+1:QW-1] == 3'b111) begin
            r = x[QW-1:0];
        end else if (x[QW+1]) begin
            r = Q_MIN;
        end else begin
            r = Q_MAX;
        end
        return r;
    endfunction

    function automatic t_q add_sat(input t_q a, input t_q b);
        logic [QW+1:0] s;
        s = {{2{a[QW-1]}}, a} + {{2{b[QW-1]}}, b};
        return sat50(s);
    endfunction

    function automatic t_q sub_sat(input t_q a, input t_q b);
        logic [QW+1:0] s;
        s = {{2{a[QW-1]}}, a} - {{2{b[QW-1]}}, b};
        return sat50(s);
    endfunction

    // signed result from sign and magnitude, saturating
    function automatic t_q from_mag(input logic neg, input logic [63:0] m);
        t_q r;
        if (neg) begin
            r = (m >= 64'h8000_0000_0000) ? Q_MIN : t_q'(-m[QW-1:0]);
        end else begin
            r = (m > 64'h7FFF_FFFF_FFFF) ? Q_MAX : t_q'(m[QW-1:0]);
        end
        return r;
    endfunction

endpackage

// ----- src/efc_delay.sv -----
// Enable-gated delay line that keeps side data aligned with the pipeline.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module efc_delay #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_sr [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[DEPTH-1];

endmodule

// ----- src/efc_mul.sv -----
// Pipelined saturating Q16.32 multiplier: 24x24 partial products, then sum.
// Depends on efc_pkg.
`timescale 1ns / 1ps

module efc_mul
    import efc_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_q   i_a,
    input  t_q   i_b,
    output t_q   o_p
);

    logic [QW-1:0] a_mag, b_mag;
    logic [QW-1:0] r_pp00, r_pp01, r_pp10, r_pp11;
    logic          r_neg;
    logic [QW:0]   mid;
    logic [2*QW-1:0] prod;
    t_q            r_p;

    assign a_mag = i_a[QW-1] ? QW'(-i_a) : QW'(i_a);
    assign b_mag = i_b[QW-1] ? QW'(-i_b) : QW'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp00 <= {24'd0, a_mag[23:0]}  * {24'd0, b_mag[23:0]};
            r_pp01 <= {24'd0, a_mag[23:0]}  * {24'd0, b_mag[47:24]};
            r_pp10 <= {24'd0, a_mag[47:24]} * {24'd0, b_mag[23:0]};
            r_pp11 <= {24'd0, a_mag[47:24]} * {24'd0, b_mag[47:24]};
            r_neg  <= i_a[QW-1] ^ i_b[QW-1];
        end
    end

    assign mid  = {1'b0, r_pp01} + {1'b0, r_pp10};
    assign prod = {r_pp11, r_pp00} + {23'd0, mid, 24'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= from_mag(r_neg, prod[2*QW-1:32]);
        end
    end

    assign o_p = r_p;

endmodule

// ----- src/efc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, Q16.32 a/b.
// Depends on efc_pkg.
`timescale 1ns / 1ps

module efc_div
    import efc_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_q   i_a,
    input  t_q   i_b,
    output t_q   o_q
);

    localparam int QB = QW;

    logic [QW-1:0] na, nb;
    logic [QW-1:0] r_rem  [0:QB];
    logic [QW-1:0] r_quo  [0:QB];
    logic [QW-1:0] r_bits [0:QB];
    logic [QW-1:0] r_nb   [0:QB];
    logic          r_neg  [0:QB];
    logic          r_ovf  [0:QB];
    t_q            r_q;

    assign na = i_a[QW-1] ? QW'(-i_a) : QW'(i_a);
    assign nb = i_b[QW-1] ? QW'(-i_b) : QW'(i_b);

    // upper numerator bits seed the remainder; if they reach the divisor the
    // quotient does not fit and saturates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {16'd0, na[QW-1:16]};
            r_quo[0]  <= '0;
            r_bits[0] <= {na[15:0], 32'd0};
            r_nb[0]   <= nb;
            r_neg[0]  <= i_a[QW-1] ^ i_b[QW-1];
            r_ovf[0]  <= ({16'd0, na[QW-1:16]} >= nb);
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [QW:0] trial;
        logic        fits;
        assign trial = {r_rem[k], r_bits[k][QW-1]};
        assign fits  = trial >= {1'b0, r_nb[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= fits ? QW'(trial - {1'b0, r_nb[k]}) : trial[QW-1:0];
                r_quo[k+1]  <= {r_quo[k][QW-2:0], fits};
                r_bits[k+1] <= {r_bits[k][QW-2:0], 1'b0};
                r_nb[k+1]   <= r_nb[k];
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= from_mag(r_neg[QB], r_ovf[QB] ? 64'hFFFF_FFFF_FFFF_FFFF
                                                 : {16'd0, r_quo[QB]});
        end
    end

    assign o_q = r_q;

endmodule

// ----- src/efc_sqrt.sv -----
// Pipelined digit-by-digit square root: floor(sqrt(v * 2^32)), one bit a stage.
// Depends on efc_pkg.
`timescale 1ns / 1ps

module efc_sqrt
    import efc_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_q   i_v,
    output t_q   o_root
);

    localparam int NB = SQRT_LAT - 1;   // result bits
    localparam int XW = 2 * NB;         // radicand width
    localparam int RW = NB + 2;         // remainder width

    logic [XW-1:0] r_x    [0:NB];
    logic [RW-1:0] r_rem  [0:NB];
    logic [NB-1:0] r_root [0:NB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= (i_v > 48'sd0) ? {i_v, 32'd0} : '0;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [RW+1:0] trem;
        logic [RW+1:0] trial;
        logic          fits;
        assign trem  = {r_rem[k], r_x[k][XW-1:XW-2]};
        assign trial = {2'b00, r_root[k], 2'b01};
        assign fits  = trem >= trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= fits ? RW'(trem - trial) : trem[RW-1:0];
                r_root[k+1] <= {r_root[k][NB-2:0], fits};
                r_x[k+1]    <= {r_x[k][XW-3:0], 2'b00};
            end
        end
    end

    assign o_root = {{(QW-NB){1'b0}}, r_root[NB]};

endmodule

// ----- src/euler_flux_and_characteristics.sv -----
// Throughput: one transaction per cycle; set by three 48-stage dividers (velocity,
// total energy over density, and s = c/(gamma-1)) and a 40-stage square root, all
// fully pipelined.
// The whole pipeline holds while a result waits under i_out_stall.
// Reset (synchronous, active low) empties the pipeline and sets gamma to 1.4.
// Depends on efc_pkg, efc_delay, efc_mul, efc_div, efc_sqrt.
`timescale 1ns / 1ps

module euler_flux_and_characteristics
    import efc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [GAMMA_W-1:0]   i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_efc_in              i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_efc_out             o_out
);

    localparam int D  = DIV_LAT;
    localparam int M  = MUL_LAT;
    localparam int S  = SQRT_LAT;
    localparam int E  = D + M + 1;      // eps registered
    localparam int C  = E + M + S;      // sound speed ready
    localparam int T  = C + D;          // s ready
    localparam int F  = T + M + 1;      // all results aligned
    localparam int NV = F + 2;

    logic [GAMMA_W-1:0] r_gamma;
    logic [GAMMA_W-1:0] gam34, gm1_34;
    t_q                 gam_q, gm1_q;
    logic               r_vld [0:NV-1];
    logic               en;

    t_q r_rho0, r_mom0, r_ene0;
    t_q u_d, a_d, gr, ge, gr_e, ge_e, rho_d, rho_e1;
    t_q usq, fm, a_m, u_m, r_eps, r_hus, fu, p, gee, r_e1, re;
    t_q fu_1, p_1, r_f1, r_f2a, u_f2, f2, c, u_c;
    t_q r_sm, r_su, r_sp, s, u_t, c_t, u_t1, hu, hus_f, sc;
    t_q r_hp, r_hm, r_r7, r_r9, r_r11, r6, r10, r_r8;
    t_q fm_f, f1_f, f2_f;
    logic [QW:0]    hu_ext;
    logic [QW+1:0]  r7_sum;
    logic [3*QW-1:0] spd_f, rgrp_f;

    assign gam34  = (r_gamma < GAMMA_MIN) ? GAMMA_MIN : r_gamma;
    assign gm1_34 = gam34 - ONE_Q;
    assign gam_q  = {{(QW-GAMMA_W){1'b0}}, gam34};
    assign gm1_q  = {{(QW-GAMMA_W){1'b0}}, gm1_34};

    assign o_out_valid = r_vld[NV-1];
    assign o_in_stall  = r_vld[NV-1] && i_out_stall;
    assign en          = !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
            for (int k = 0; k < NV; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_gamma <= i_cfg_wdata;
            end
            if (en) begin
                r_vld[0] <= i_in_valid;
                for (int k = 1; k < NV; k++) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // entry: density floor
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rho0 <= (i_in.density < FLOOR_Q) ? FLOOR_Q : i_in.density;
            r_mom0 <= i_in.momentum;
            r_ene0 <= i_in.total_energy;
        end
    end

    efc_div u_div_u (.i_clk, .i_en(en), .i_a(r_mom0), .i_b(r_rho0), .o_q(u_d));
    efc_div u_div_a (.i_clk, .i_en(en), .i_a(r_ene0), .i_b(r_rho0), .o_q(a_d));
    efc_mul u_mul_gr (.i_clk, .i_en(en), .i_a(gm1_q), .i_b(r_rho0), .o_p(gr));
    efc_mul u_mul_ge (.i_clk, .i_en(en), .i_a(gam_q), .i_b(gm1_q), .o_p(ge));

    efc_delay #(.WIDTH(QW), .DEPTH(E-M)) u_dl_gr
        (.i_clk, .i_en(en), .i_d(gr), .o_q(gr_e));
    efc_delay #(.WIDTH(QW), .DEPTH(E-M)) u_dl_ge
        (.i_clk, .i_en(en), .i_d(ge), .o_q(ge_e));
    efc_delay #(.WIDTH(QW), .DEPTH(D)) u_dl_rho_d
        (.i_clk, .i_en(en), .i_d(r_rho0), .o_q(rho_d));
    efc_delay #(.WIDTH(QW), .DEPTH(E+1)) u_dl_rho_e
        (.i_clk, .i_en(en), .i_d(r_rho0), .o_q(rho_e1));

    efc_mul u_mul_usq (.i_clk, .i_en(en), .i_a(u_d), .i_b(u_d), .o_p(usq));
    efc_mul u_mul_fm (.i_clk, .i_en(en), .i_a(rho_d), .i_b(u_d), .o_p(fm));
    efc_delay #(.WIDTH(QW), .DEPTH(M)) u_dl_a
        (.i_clk, .i_en(en), .i_d(a_d), .o_q(a_m));
    efc_delay #(.WIDTH(QW), .DEPTH(M)) u_dl_um
        (.i_clk, .i_en(en), .i_d(u_d), .o_q(u_m));

    // specific internal energy with floor; u*u/2 is never negative
    always_ff @(posedge i_clk) begin
        t_q e;
        if (en) begin
            e      = sub_sat(a_m, {1'b0, usq[QW-1:1]});
            r_eps <= (e < FLOOR_Q) ? FLOOR_Q : e;
            r_hus <= {1'b0, usq[QW-1:1]};
            r_e1  <= add_sat(r_eps, r_hus);
        end
    end

    efc_mul u_mul_fu (.i_clk, .i_en(en), .i_a(fm), .i_b(u_m), .o_p(fu));
    efc_mul u_mul_p (.i_clk, .i_en(en), .i_a(gr_e), .i_b(r_eps), .o_p(p));
    efc_mul u_mul_gee (.i_clk, .i_en(en), .i_a(ge_e), .i_b(r_eps), .o_p(gee));
    efc_mul u_mul_re (.i_clk, .i_en(en), .i_a(rho_e1), .i_b(r_e1), .o_p(re));

    efc_delay #(.WIDTH(QW), .DEPTH(1)) u_dl_fu
        (.i_clk, .i_en(en), .i_d(fu), .o_q(fu_1));
    efc_delay #(.WIDTH(QW), .DEPTH(1)) u_dl_p
        (.i_clk, .i_en(en), .i_d(p), .o_q(p_1));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1  <= add_sat(fu_1, p);
            r_f2a <= add_sat(re, p_1);
        end
    end

    efc_delay #(.WIDTH(QW), .DEPTH(2*M+3)) u_dl_uf2
        (.i_clk, .i_en(en), .i_d(u_d), .o_q(u_f2));
    efc_mul u_mul_f2 (.i_clk, .i_en(en), .i_a(r_f2a), .i_b(u_f2), .o_p(f2));

    efc_sqrt u_sqrt (.i_clk, .i_en(en), .i_v(gee), .o_root(c));
    efc_delay #(.WIDTH(QW), .DEPTH(C-D)) u_dl_uc
        (.i_clk, .i_en(en), .i_d(u_d), .o_q(u_c));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sm <= sub_sat(u_c, c);
            r_su <= u_c;
            r_sp <= add_sat(u_c, c);
        end
    end

    efc_div u_div_s (.i_clk, .i_en(en), .i_a(c), .i_b(gm1_q), .o_q(s));
    efc_delay #(.WIDTH(QW), .DEPTH(D)) u_dl_ut
        (.i_clk, .i_en(en), .i_d(u_c), .o_q(u_t));
    efc_delay #(.WIDTH(QW), .DEPTH(D)) u_dl_ct
        (.i_clk, .i_en(en), .i_d(c), .o_q(c_t));
    efc_delay #(.WIDTH(QW), .DEPTH(1)) u_dl_ut1
        (.i_clk, .i_en(en), .i_d(u_t), .o_q(u_t1));

    // u/2 rounded toward zero
    assign hu_ext = {u_t[QW-1], u_t} + {{QW{1'b0}}, u_t[QW-1]};
    assign hu     = hu_ext[QW:1];
    assign r7_sum = {QW+2{1'b0}} - {{2{s[QW-1]}}, s} - {{2{u_t[QW-1]}}, u_t};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hp  <= add_sat(hu, s);
            r_hm  <= sub_sat(hu, s);
            r_r7  <= sat50(r7_sum);
            r_r9  <= sub_sat('0, u_t);
            r_r11 <= sub_sat(s, u_t);
        end
    end

    efc_mul u_mul_sc (.i_clk, .i_en(en), .i_a(s), .i_b(c_t), .o_p(sc));
    efc_mul u_mul_r6 (.i_clk, .i_en(en), .i_a(u_t1), .i_b(r_hp), .o_p(r6));
    efc_mul u_mul_r10 (.i_clk, .i_en(en), .i_a(u_t1), .i_b(r_hm), .o_p(r10));
    efc_delay #(.WIDTH(QW), .DEPTH(T+M-E)) u_dl_hus
        (.i_clk, .i_en(en), .i_d(r_hus), .o_q(hus_f));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r8 <= sub_sat(hus_f, sc);
        end
    end

    // align everything to the last result
    efc_delay #(.WIDTH(QW), .DEPTH(F-D-M)) u_dl_fmf
        (.i_clk, .i_en(en), .i_d(fm), .o_q(fm_f));
    efc_delay #(.WIDTH(QW), .DEPTH(F-E-M-1)) u_dl_f1f
        (.i_clk, .i_en(en), .i_d(r_f1), .o_q(f1_f));
    efc_delay #(.WIDTH(QW), .DEPTH(F-E-2*M-2)) u_dl_f2f
        (.i_clk, .i_en(en), .i_d(f2), .o_q(f2_f));
    efc_delay #(.WIDTH(3*QW), .DEPTH(F-C-1)) u_dl_spd
        (.i_clk, .i_en(en), .i_d({r_sm, r_su, r_sp}), .o_q(spd_f));
    efc_delay #(.WIDTH(3*QW), .DEPTH(M)) u_dl_rgrp
        (.i_clk, .i_en(en), .i_d({r_r7, r_r9, r_r11}), .o_q(rgrp_f));

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out.flux_mass      <= fm_f;
            o_out.flux_momentum  <= f1_f;
            o_out.flux_energy    <= f2_f;
            o_out.speed_minus    <= spd_f[3*QW-1:2*QW];
            o_out.speed_mid      <= spd_f[2*QW-1:QW];
            o_out.speed_plus     <= spd_f[QW-1:0];
            o_out.left_row0_col0 <= r6;
            o_out.left_row0_col1 <= rgrp_f[3*QW-1:2*QW];
            o_out.left_row1_col0 <= r_r8;
            o_out.left_row1_col1 <= rgrp_f[2*QW-1:QW];
            o_out.left_row2_col0 <= r10;
            o_out.left_row2_col1 <= rgrp_f[QW-1:0];
        end
    end

endmodule

// ----- src/efc_checker.sv -----
// Port-level checks for euler_flux_and_characteristics, bound to the top level.
// Depends on efc_pkg.
`timescale 1ns / 1ps

module efc_checker
    import efc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [GAMMA_W-1:0] i_cfg_wdata,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input t_efc_in            i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input t_efc_out           o_out
);

    // a held result stalls the input side and nothing else does
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow output hold");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled transaction changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // sound speed is never negative
    a_speed_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_out.speed_minus) <= $signed(o_out.speed_mid)
                      && $signed(o_out.speed_mid) <= $signed(o_out.speed_plus)))
        else $error("characteristic speeds out of order");

    a_neg_u: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.speed_mid != Q_MIN)
            |-> (o_out.left_row1_col1 == t_q'(-o_out.speed_mid)))
        else $error("eigenvector entry does not match velocity");

endmodule

bind euler_flux_and_characteristics efc_checker u_efc_checker (.*);
